// ===== rtl/chunked_upload_session_fsm_core_assert.svh =====
// Assertion helpers for the upload session core.
`ifndef CHUNKED_UPLOAD_SESSION_FSM_CORE_ASSERT_SVH
`define CHUNKED_UPLOAD_SESSION_FSM_CORE_ASSERT_SVH

// Same-cycle implication.
`define CUSF_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("upload core: same-cycle check failed");

// Next-cycle implication.
`define CUSF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("upload core: next-cycle check failed");

`endif

// ===== rtl/cusf_pkg.sv =====
`default_nettype none

package cusf_pkg;

    localparam int unsigned OFFSET_BITS_DEFAULT = 32;

    localparam int unsigned OFFSET_FIELD_W = 32;
    localparam int unsigned LENGTH_W       = 16;
    localparam int unsigned LIMIT_W        = 8;
    localparam int unsigned STALL_W        = 9;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned CFG_INDEX_W    = 3;

    localparam logic [LENGTH_W-1:0] SEG_LEN_RESET = 16'd32;
    localparam logic [STALL_W-1:0]  STALL_MAX     = 9'd511;

    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_BYTES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEG_LEN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RESTART = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_NOPROG  = 3'd4;

    localparam logic [1:0] ACT_SEND     = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_FAIL     = 2'd2;

    localparam logic [1:0] KIND_OK        = 2'd0;
    localparam logic [1:0] KIND_TRANSIENT = 2'd1;

    localparam logic FUNC_PLAN = 1'b0;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    localparam logic [3:0] ERR_NONE           = 4'd0;
    localparam logic [3:0] ERR_ALREADY_FAILED = 4'd1;
    localparam logic [3:0] ERR_NO_OFFSET      = 4'd2;
    localparam logic [3:0] ERR_BEYOND_IMAGE   = 4'd3;
    localparam logic [3:0] ERR_MISMATCH       = 4'd4;
    localparam logic [3:0] ERR_RESTARTS       = 4'd5;
    localparam logic [3:0] ERR_STALLED        = 4'd6;
    localparam logic [3:0] ERR_TRANSIENT      = 4'd7;
    localparam logic [3:0] ERR_DEVICE         = 4'd8;

    typedef struct packed {
        logic [1:0]                action;
        logic [OFFSET_FIELD_W-1:0] req_offset;
        logic [LENGTH_W-1:0]       req_length;
        logic                      req_first_packet;
        logic [3:0]                error_code;
        logic                      done_match_known;
        logic                      done_match_value;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/chunked_upload_session_fsm_core.sv =====
// The result of an accepted transaction is registered at the accepting edge.
// Throughput: one transaction per cycle; session state is updated at the accepting edge.
// The only hold-off is a result waiting under out_stall, which stalls the input.
// Reset (rst_n low, asynchronous): phase idle, offsets and counters zero, first packet
// pending, registers back to total size 0, segment length 32, limits 0.
`default_nettype none

module chunked_upload_session_fsm_core
    import cusf_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [1:0]                failure_kind,
    input  logic                      has_offset,
    input  logic [OFFSET_FIELD_W-1:0] resp_offset,
    input  logic                      match_known,
    input  logic                      match_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                action,
    output logic [OFFSET_FIELD_W-1:0] req_offset,
    output logic [LENGTH_W-1:0]       req_length,
    output logic                      req_first_packet,
    output logic [3:0]                error_code,
    output logic                      done_match_known,
    output logic                      done_match_value
);

    typedef logic [OFFSET_BITS-1:0] ofs_t;

    ofs_t                total_bytes_reg;
    logic [LENGTH_W-1:0] seg_len_reg;
    logic [LIMIT_W-1:0]  max_chunk_retries_reg;
    logic [LIMIT_W-1:0]  restart_limit_reg;
    logic [LIMIT_W-1:0]  noprog_limit_reg;

    logic [1:0]          phase_reg, phase_next;
    ofs_t                confirmed_offset_reg, confirmed_offset_next;
    logic                first_pending_reg, first_pending_next;
    ofs_t                flight_offset_reg, flight_offset_next;
    logic [LENGTH_W-1:0] flight_length_reg, flight_length_next;
    logic                flight_first_reg, flight_first_next;
    logic [LIMIT_W-1:0]  retry_count_reg, retry_count_next;
    logic [LIMIT_W-1:0]  restart_count_reg, restart_count_next;
    logic [STALL_W-1:0]  stall_count_reg, stall_count_next;

    logic                out_valid_reg, out_valid_next;
    result_t             result_reg, result_next;

    logic                accept;
    ofs_t                rep;
    ofs_t                send_off;
    ofs_t                rem;
    logic [LENGTH_W-1:0] send_len;
    logic [STALL_W-1:0]  stall_inc;
    logic                plan_send;
    logic                retry_send;

    assign in_stall       = out_valid_reg && out_stall;
    assign accept         = in_valid && !in_stall;
    assign out_valid_next = accept || in_stall;

    assign rep       = OFFSET_BITS'(resp_offset);
    assign stall_inc = (stall_count_reg == STALL_MAX) ? stall_count_reg
                                                      : stall_count_reg + 1'b1;

    always_comb
    begin
        phase_next            = phase_reg;
        confirmed_offset_next = confirmed_offset_reg;
        first_pending_next    = first_pending_reg;
        flight_offset_next    = flight_offset_reg;
        flight_length_next    = flight_length_reg;
        flight_first_next     = flight_first_reg;
        retry_count_next      = retry_count_reg;
        restart_count_next    = restart_count_reg;
        stall_count_next      = stall_count_reg;
        result_next           = '0;
        plan_send             = 1'b0;
        retry_send            = 1'b0;

        if (func == FUNC_PLAN)
        begin
            if (phase_reg == PH_FAILED)
            begin
                result_next.action     = ACT_FAIL;
                result_next.error_code = ERR_ALREADY_FAILED;
            end
            else if (confirmed_offset_reg >= total_bytes_reg)
            begin
                result_next.action = ACT_COMPLETE;
            end
            else
            begin
                plan_send = 1'b1;
            end
        end
        else if (failure_kind != KIND_OK)
        begin
            if (failure_kind == KIND_TRANSIENT && retry_count_reg < max_chunk_retries_reg)
            begin
                retry_count_next = retry_count_reg + 1'b1;
                retry_send       = 1'b1;
            end
            else
            begin
                phase_next             = PH_FAILED;
                result_next.action     = ACT_FAIL;
                result_next.error_code = (failure_kind == KIND_TRANSIENT) ? ERR_TRANSIENT
                                                                          : ERR_DEVICE;
            end
        end
        else if (!has_offset)
        begin
            phase_next             = PH_FAILED;
            result_next.action     = ACT_FAIL;
            result_next.error_code = ERR_NO_OFFSET;
        end
        else if (rep > total_bytes_reg)
        begin
            phase_next             = PH_FAILED;
            result_next.action     = ACT_FAIL;
            result_next.error_code = ERR_BEYOND_IMAGE;
        end
        else if (rep == total_bytes_reg)
        begin
            if (match_known && !match_value)
            begin
                phase_next             = PH_FAILED;
                result_next.action     = ACT_FAIL;
                result_next.error_code = ERR_MISMATCH;
            end
            else
            begin
                confirmed_offset_next        = rep;
                phase_next                   = PH_DONE;
                result_next.action           = ACT_COMPLETE;
                result_next.done_match_known = match_known;
                result_next.done_match_value = match_known && match_value;
            end
        end
        else if (rep == '0)
        begin
            if (restart_count_reg >= restart_limit_reg)
            begin
                phase_next             = PH_FAILED;
                result_next.action     = ACT_FAIL;
                result_next.error_code = ERR_RESTARTS;
            end
            else
            begin
                restart_count_next    = restart_count_reg + 1'b1;
                confirmed_offset_next = '0;
                first_pending_next    = 1'b1;
                stall_count_next      = '0;
                retry_count_next      = '0;
                plan_send             = 1'b1;
            end
        end
        else if (flight_first_reg || rep > confirmed_offset_reg)
        begin
            confirmed_offset_next = rep;
            first_pending_next    = 1'b0;
            stall_count_next      = '0;
            retry_count_next      = '0;
            plan_send             = 1'b1;
        end
        else
        begin
            // no progress: count stays even when it fails
            stall_count_next = stall_inc;
            if (stall_inc > {1'b0, noprog_limit_reg})
            begin
                phase_next             = PH_FAILED;
                result_next.action     = ACT_FAIL;
                result_next.error_code = ERR_STALLED;
            end
            else
            begin
                confirmed_offset_next = rep;
                first_pending_next    = 1'b0;
                retry_count_next      = '0;
                plan_send             = 1'b1;
            end
        end

        send_off = first_pending_next ? '0 : confirmed_offset_next;
        rem      = total_bytes_reg - send_off;
        if (send_off >= total_bytes_reg)
        begin
            send_len = '0;
        end
        else if (rem < OFFSET_BITS'(seg_len_reg))
        begin
            send_len = rem[LENGTH_W-1:0];
        end
        else
        begin
            send_len = seg_len_reg;
        end

        if (plan_send)
        begin
            flight_offset_next           = send_off;
            flight_length_next           = send_len;
            flight_first_next            = first_pending_next;
            phase_next                   = PH_SENDING;
            result_next.action           = ACT_SEND;
            result_next.req_offset       = OFFSET_FIELD_W'(send_off);
            result_next.req_length       = send_len;
            result_next.req_first_packet = first_pending_next;
        end

        if (retry_send)
        begin
            phase_next                   = PH_SENDING;
            result_next.action           = ACT_SEND;
            result_next.req_offset       = OFFSET_FIELD_W'(flight_offset_reg);
            result_next.req_length       = flight_length_reg;
            result_next.req_first_packet = flight_first_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bytes_reg       <= '0;
            seg_len_reg           <= SEG_LEN_RESET;
            max_chunk_retries_reg <= '0;
            restart_limit_reg     <= '0;
            noprog_limit_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL_BYTES: total_bytes_reg       <= OFFSET_BITS'(cfg_data);
                REG_SEG_LEN:     seg_len_reg           <= cfg_data[LENGTH_W-1:0];
                REG_MAX_RETRIES: max_chunk_retries_reg <= cfg_data[LIMIT_W-1:0];
                REG_MAX_RESTART: restart_limit_reg     <= cfg_data[LIMIT_W-1:0];
                REG_MAX_NOPROG:  noprog_limit_reg      <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            confirmed_offset_reg <= '0;
            first_pending_reg    <= 1'b1;
            flight_offset_reg    <= '0;
            flight_length_reg    <= '0;
            flight_first_reg     <= 1'b0;
            retry_count_reg      <= '0;
            restart_count_reg    <= '0;
            stall_count_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            confirmed_offset_reg <= confirmed_offset_next;
            first_pending_reg    <= first_pending_next;
            flight_offset_reg    <= flight_offset_next;
            flight_length_reg    <= flight_length_next;
            flight_first_reg     <= flight_first_next;
            retry_count_reg      <= retry_count_next;
            restart_count_reg    <= restart_count_next;
            stall_count_reg      <= stall_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = result_reg.action;
    assign req_offset       = result_reg.req_offset;
    assign req_length       = result_reg.req_length;
    assign req_first_packet = result_reg.req_first_packet;
    assign error_code       = result_reg.error_code;
    assign done_match_known = result_reg.done_match_known;
    assign done_match_value = result_reg.done_match_value;

endmodule

`default_nettype wire

// ===== rtl/cusf_checker.sv =====
`default_nettype none

`include "chunked_upload_session_fsm_core_assert.svh"

module cusf_checker
    import cusf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [1:0]                action,
    input  logic [OFFSET_FIELD_W-1:0] req_offset,
    input  logic [LENGTH_W-1:0]       req_length,
    input  logic                      req_first_packet,
    input  logic [3:0]                error_code,
    input  logic                      done_match_known,
    input  logic                      done_match_value
);

    // every accepted transaction yields a result on the next cycle
    `CUSF_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && !in_stall, out_valid)

    `CUSF_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(action) && $stable(req_offset) && $stable(req_length) && $stable(error_code))

    `CUSF_ASSERT_IMPLY(a_send_fields, clk, rst_n, out_valid && action != ACT_SEND, req_offset == '0 && req_length == '0 && !req_first_packet)

    `CUSF_ASSERT_IMPLY(a_code_on_fail, clk, rst_n, out_valid, (action == ACT_FAIL) == (error_code != ERR_NONE))

    `CUSF_ASSERT_IMPLY(a_match_on_done, clk, rst_n, out_valid && action != ACT_COMPLETE, !done_match_known && !done_match_value)

endmodule

bind chunked_upload_session_fsm_core cusf_checker u_cusf_checker (.*);

`default_nettype wire

// ===== tb/sv/chunked_upload_session_fsm_core_tb.sv =====
module chunked_upload_session_fsm_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cusf_pkg::*;

    localparam logic       FUNC_RESPONSE  = ~FUNC_PLAN;
    localparam logic [1:0] KIND_OTHER     = 2'd2;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;
    localparam int         QUIET_LIMIT    = 5000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 4;

    typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} flow_mode_t;

    typedef struct packed {
        logic [1:0]          phase;
        logic [31:0]         confirmed;
        logic                first_pending;
        logic [31:0]         flight_offset;
        logic [LENGTH_W-1:0] flight_length;
        logic                flight_first;
        logic [LIMIT_W-1:0]  retries_used;
        logic [LIMIT_W-1:0]  restarts_used;
        logic [STALL_W-1:0]  stall_run;
    } session_t;

    typedef struct packed {
        logic [31:0]         total_bytes;
        logic [LENGTH_W-1:0] seg_len;
        logic [LIMIT_W-1:0]  max_retries;
        logic [LIMIT_W-1:0]  restart_limit;
        logic [LIMIT_W-1:0]  noprog_limit;
    } settings_t;

    typedef struct packed {
        logic        func;
        logic [1:0]  kind;
        logic        has_off;
        logic [31:0] offset;
        logic        mk;
        logic        mv;
    } upload_event_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      func = 1'b0;
    logic [1:0]                failure_kind = '0;
    logic                      has_offset = 1'b0;
    logic [OFFSET_FIELD_W-1:0] resp_offset = '0;
    logic                      match_known = 1'b0;
    logic                      match_value = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                action;
    logic [OFFSET_FIELD_W-1:0] req_offset;
    logic [LENGTH_W-1:0]       req_length;
    logic                      req_first_packet;
    logic [3:0]                error_code;
    logic                      done_match_known;
    logic                      done_match_value;

    upload_event_t pending_events[$];
    result_t       expected_steps[$];
    settings_t     regs;
    session_t      model_session;
    session_t      plan_session;
    result_t       plan_last;
    flow_mode_t    flow = FLOW_FREE;
    int            mismatches = 0;
    int            quiet_cycles = 0;
    int            hold_token = 0;
    int            hold_served = 0;
    int            hold_left = 0;

    chunked_upload_session_fsm_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .failure_kind     (failure_kind),
        .has_offset       (has_offset),
        .resp_offset      (resp_offset),
        .match_known      (match_known),
        .match_value      (match_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action           (action),
        .req_offset       (req_offset),
        .req_length       (req_length),
        .req_first_packet (req_first_packet),
        .error_code       (error_code),
        .done_match_known (done_match_known),
        .done_match_value (done_match_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic session_t fresh_session();
        session_t s;
        s = '0;
        s.phase = PH_IDLE;
        s.first_pending = 1'b1;
        return s;
    endfunction

    function automatic result_t fail_step(inout session_t s, input logic [3:0] code);
        result_t r;
        r = '0;
        s.phase = PH_FAILED;
        r.action = ACT_FAIL;
        r.error_code = code;
        return r;
    endfunction

    function automatic result_t send_chunk(inout session_t s, input logic [31:0] off,
                                           input logic [LENGTH_W-1:0] len, input logic first);
        result_t r;
        r = '0;
        s.flight_offset = off;
        s.flight_length = len;
        s.flight_first = first;
        s.phase = PH_SENDING;
        r.action = ACT_SEND;
        r.req_offset = off;
        r.req_length = len;
        r.req_first_packet = first;
        return r;
    endfunction

    function automatic result_t send_next(inout session_t s, input settings_t c);
        logic [31:0]         off;
        logic [31:0]         rem;
        logic [LENGTH_W-1:0] len;
        off = s.first_pending ? 32'd0 : s.confirmed;
        len = '0;
        if (off < c.total_bytes)
        begin
            rem = c.total_bytes - off;
            len = (rem < c.seg_len) ? rem[LENGTH_W-1:0] : c.seg_len;
        end
        return send_chunk(s, off, len, s.first_pending);
    endfunction

    // one event in, one step out; session state advanced in place
    function automatic result_t session_step(inout session_t s, input settings_t c,
                                             input upload_event_t e);
        result_t r;
        r = '0;
        if (e.func == FUNC_PLAN)
        begin
            if (s.phase == PH_FAILED)
            begin
                r.action = ACT_FAIL;
                r.error_code = ERR_ALREADY_FAILED;
                return r;
            end
            if (s.confirmed >= c.total_bytes)
            begin
                r.action = ACT_COMPLETE;
                return r;
            end
            return send_next(s, c);
        end
        if (e.kind != KIND_OK)
        begin
            if (e.kind == KIND_TRANSIENT && s.retries_used < c.max_retries)
            begin
                s.retries_used = s.retries_used + 1'b1;
                return send_chunk(s, s.flight_offset, s.flight_length, s.flight_first);
            end
            return fail_step(s, (e.kind == KIND_TRANSIENT) ? ERR_TRANSIENT : ERR_DEVICE);
        end
        if (!e.has_off)
            return fail_step(s, ERR_NO_OFFSET);
        if (e.offset > c.total_bytes)
            return fail_step(s, ERR_BEYOND_IMAGE);
        if (e.offset == c.total_bytes)
        begin
            if (e.mk && !e.mv)
                return fail_step(s, ERR_MISMATCH);
            s.confirmed = e.offset;
            s.phase = PH_DONE;
            r.action = ACT_COMPLETE;
            r.done_match_known = e.mk;
            r.done_match_value = e.mk & e.mv;
            return r;
        end
        if (e.offset == 32'd0)
        begin
            if (s.restarts_used >= c.restart_limit)
                return fail_step(s, ERR_RESTARTS);
            s.restarts_used = s.restarts_used + 1'b1;
            s.confirmed = '0;
            s.first_pending = 1'b1;
            s.stall_run = '0;
            s.retries_used = '0;
            return send_next(s, c);
        end
        if (s.flight_first || e.offset > s.confirmed)
        begin
            s.confirmed = e.offset;
            s.first_pending = 1'b0;
            s.stall_run = '0;
            s.retries_used = '0;
            return send_next(s, c);
        end
        if (s.stall_run != STALL_MAX)
            s.stall_run = s.stall_run + 1'b1;
        if (s.stall_run > c.noprog_limit)
            return fail_step(s, ERR_STALLED);
        s.confirmed = e.offset;
        s.first_pending = 1'b0;
        s.retries_used = '0;
        return send_next(s, c);
    endfunction

    function automatic bit sender_waits();
        case (flow)
            FLOW_SENDER_GAPS: return $urandom_range(99) < 86;
            FLOW_BOTH:        return $urandom_range(99) < 28;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_waits();
        case (flow)
            FLOW_RECEIVER_STALLS: return $urandom_range(99) < 86;
            FLOW_BOTH:            return $urandom_range(99) < 28;
            default:              return 1'b0;
        endcase
    endfunction

    task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
        $display("[%0t] %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                 $time, name, want, want, got, got);
        mismatches++;
    endtask

    task automatic compare_step(input result_t want, input result_t got);
        if (got.action !== want.action)
            flag_field("action", 32'(want.action), 32'(got.action));
        if (got.req_offset !== want.req_offset)
            flag_field("req_offset", want.req_offset, got.req_offset);
        if (got.req_length !== want.req_length)
            flag_field("req_length", 32'(want.req_length), 32'(got.req_length));
        if (got.req_first_packet !== want.req_first_packet)
            flag_field("req_first_packet", 32'(want.req_first_packet),
                       32'(got.req_first_packet));
        if (got.error_code !== want.error_code)
            flag_field("error_code", 32'(want.error_code), 32'(got.error_code));
        if (got.done_match_known !== want.done_match_known)
            flag_field("done_match_known", 32'(want.done_match_known),
                       32'(got.done_match_known));
        if (got.done_match_value !== want.done_match_value)
            flag_field("done_match_value", 32'(want.done_match_value),
                       32'(got.done_match_value));
    endtask

    // sender
    always @(posedge clk)
    begin : drive
        upload_event_t e;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_events.size() != 0 && !sender_waits())
            begin
                e = pending_events.pop_front();
                in_valid     <= 1'b1;
                func         <= e.func;
                failure_kind <= e.kind;
                has_offset   <= e.has_off;
                resp_offset  <= e.offset;
                match_known  <= e.mk;
                match_value  <= e.mv;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_token != hold_served)
        begin
            hold_served <= hold_token;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= receiver_waits();
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin : observe
        result_t       got;
        upload_event_t e;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                got = {action, req_offset, req_length, req_first_packet, error_code,
                       done_match_known, done_match_value};
                if (expected_steps.size() == 0)
                begin
                    $display("[%0t] unexpected step: expected none, actual action %0d",
                             $time, action);
                    mismatches++;
                end
                else
                    compare_step(expected_steps.pop_front(), got);
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                e = {func, failure_kind, has_offset, resp_offset, match_known, match_value};
                expected_steps.push_back(session_step(model_session, regs, e));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("chunked_upload_session_fsm_core_tb failed");
                $finish;
            end
        end
    end

    task automatic queue_event(input logic f, input logic [1:0] k, input logic ho,
                               input logic [31:0] off, input logic mk, input logic mv);
        upload_event_t e;
        e = {f, k, ho, off, mk, mv};
        plan_last = session_step(plan_session, regs, e);
        pending_events.push_back(e);
    endtask

    // checked away from the active edge so the driver's decision is settled
    task automatic settle();
        while (pending_events.size() != 0 || in_valid || expected_steps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic start_phase(input flow_mode_t m, input logic [31:0] img,
                               input logic [LENGTH_W-1:0] chunk, input logic [LIMIT_W-1:0] rtry,
                               input logic [LIMIT_W-1:0] rstr, input logic [LIMIT_W-1:0] noprog);
        int idx;
        settle();
        write_reg(REG_TOTAL_BYTES, img);
        write_reg(REG_SEG_LEN, {16'($urandom), chunk});
        write_reg(REG_MAX_RETRIES, {24'($urandom), rtry});
        write_reg(REG_MAX_RESTART, {24'($urandom), rstr});
        write_reg(REG_MAX_NOPROG, {24'($urandom), noprog});
        // indexes past the last register must be ignored
        for (idx = int'(REG_MAX_NOPROG) + 1; idx < (1 << CFG_INDEX_W); idx++)
            write_reg(idx[CFG_INDEX_W-1:0], $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = {img, chunk, rtry, rstr, noprog};
        flow = m;
    endtask

    // mostly well-formed answers to the step last issued, some noise
    task automatic random_session(input int count);
        int          n;
        int          pick;
        logic [31:0] img;
        logic [31:0] next_off;
        img = regs.total_bytes;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            next_off = plan_last.req_offset + plan_last.req_length;
            if (pick < 8)
                queue_event(1'($urandom_range(1)), 2'($urandom_range(3)),
                            1'($urandom_range(1)), $urandom,
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (plan_last.action != ACT_SEND)
            begin
                if (pick < 55)
                    queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
                else if (pick < 70)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, '0, 1'b0, 1'b0);
                else
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, $urandom_range(img),
                                1'($urandom_range(1)), 1'b1);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, next_off,
                                1'($urandom_range(1)), $urandom_range(99) >= 15);
                else if (pick < 70)
                    queue_event(FUNC_RESPONSE, KIND_TRANSIENT, 1'($urandom_range(1)),
                                $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
                else if (pick < 74)
                    queue_event(FUNC_RESPONSE, $urandom_range(1) ? KIND_OTHER : KIND_RESERVED,
                                1'($urandom_range(1)), next_off, 1'b0, 1'b0);
                else if (pick < 79)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, '0, 1'b0, 1'b0);
                else if (pick < 88)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1,
                                $urandom_range(plan_session.confirmed), 1'b0, 1'b0);
                else if (pick < 92)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, img + 1 + $urandom_range(40),
                                1'b0, 1'b0);
                else if (pick < 95)
                    queue_event(FUNC_RESPONSE, KIND_OK, 1'b0, next_off, 1'b1, 1'b1);
                else
                    queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin : stimulus
        regs = {32'd0, SEG_LEN_RESET, 8'd0, 8'd0, 8'd0};
        model_session = fresh_session();
        plan_session = fresh_session();
        plan_last = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // power-on registers: empty image
        queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd0, 1'b1, 1'b1);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd0, 1'b0, 1'b1);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd0, 1'b1, 1'b0);
        queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd5, 1'b0, 1'b0);

        start_phase(FLOW_FREE, 32'd100, 16'd32, 8'd1, 8'd1, 8'd1);
        queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_TRANSIENT, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_TRANSIENT, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd32, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OTHER, 1'b1, 32'd64, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_RESERVED, 1'b1, 32'd64, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b0, 32'd64, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd32, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd32, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd64, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd96, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'd100, 1'b0, 1'b1);
        queue_event(FUNC_PLAN, KIND_OK, 1'b0, '0, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);

        start_phase(FLOW_FREE, $urandom_range(4000, 300), 16'($urandom_range(128, 32)),
                    8'd3, 8'd4, 8'd3);
        hold_token++;
        random_session(180);

        start_phase(FLOW_SENDER_GAPS, $urandom_range(3000, 200), 16'($urandom_range(300, 32)),
                    8'd0, 8'd0, 8'd0);
        random_session(170);

        start_phase(FLOW_RECEIVER_STALLS, 32'd2000, 16'd32, 8'd255, 8'd255, 8'd255);
        random_session(170);

        start_phase(FLOW_BOTH, $urandom_range(300000, 70000), 16'hFFFF, 8'd2, 8'd2, 8'd2);
        random_session(170);

        // long run of non-advancing answers: counter must saturate, not wrap
        start_phase(FLOW_FREE, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0);
        repeat (530)
            queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0);
        queue_event(FUNC_RESPONSE, KIND_OK, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        random_session(100);

        start_phase(FLOW_SENDER_GAPS, 32'd500, 16'd0, 8'd1, 8'd1, 8'd1);
        random_session(50);
        start_phase(FLOW_RECEIVER_STALLS, 32'd700, 16'd31, 8'd1, 8'd1, 8'd1);
        random_session(50);

        start_phase(FLOW_RECEIVER_STALLS, 32'd90, 16'd7, 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        random_session(100);

        start_phase(FLOW_BOTH, 32'd0, 16'd32, 8'd0, 8'd0, 8'd0);
        random_session(60);

        start_phase(FLOW_FREE, $urandom, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        random_session(120);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("chunked_upload_session_fsm_core_tb passed");
        else
            $display("chunked_upload_session_fsm_core_tb failed");
        $finish;
    end

endmodule
